// ----- rtl/core/kfv_pkg.sv -----
// shared types, constants and saturating fixed-point helpers for the kalman filter core
`timescale 1ns / 1ps

package kfv_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int PW        = 2 * DW;
    localparam int QW        = DW + FB;
    localparam int DIV_STEPS = DW + FB;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int CFG_W     = 31;
    localparam int DT_W      = 16;

    typedef logic signed [DW-1:0] word_t;

    localparam word_t WMAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(DW-1){1'b0}}};
    localparam word_t ONE  = {{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

    typedef enum logic [2:0] {
        CFG_STEP_TIME = 3'd0,
        CFG_Q_POS     = 3'd1,
        CFG_Q_VEL     = 3'd2,
        CFG_R_POS     = 3'd3,
        CFG_R_VEL     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic  start;
        word_t num;
        word_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quo;
    } div_rsp_t;

    function automatic word_t sadd(input word_t a, input word_t b);
        logic signed [DW:0] s;
        word_t r;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            r = s[DW] ? WMIN : WMAX;
        end else begin
            r = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic word_t ssub(input word_t a, input word_t b);
        logic signed [DW:0] s;
        word_t r;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            r = s[DW] ? WMIN : WMAX;
        end else begin
            r = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic word_t sneg(input word_t a);
        return (a == WMIN) ? WMAX : -a;
    endfunction

    function automatic word_t sat_mag(input logic neg, input logic [PW-1:0] mag);
        word_t r;
        if (mag[PW-1:DW-1] != '0) begin
            r = neg ? WMIN : WMAX;
        end else if (neg) begin
            r = -word_t'(mag[DW-1:0]);
        end else begin
            r = word_t'(mag[DW-1:0]);
        end
        return r;
    endfunction

    function automatic word_t round_prod(input logic signed [PW-1:0] p);
        logic            neg;
        logic [PW-1:0]   mag;
        logic [PW-1:0]   rnd;
        neg = p[PW-1];
        mag = neg ? PW'(-p) : PW'(p);
        rnd = mag + (PW'(1) << (FB - 1));
        return sat_mag(neg, rnd >> FB);
    endfunction

endpackage

// ----- rtl/core/kfv_lane.sv -----
// one multiplier lane: registered product, then registered rounding and saturation
`timescale 1ns / 1ps

module kfv_lane import kfv_pkg::*; (
    input  logic  aclk,
    input  word_t op_a,
    input  word_t op_b,
    output word_t prod
);

    logic signed [PW-1:0] mul_reg;
    word_t                prod_reg;

    always_ff @(posedge aclk) begin
        mul_reg  <= op_a * op_b;
        prod_reg <= round_prod(mul_reg);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/kfv_merge.sv -----
// merging stage: saturating sum of the two lane products
`timescale 1ns / 1ps

module kfv_merge import kfv_pkg::*; (
    input  logic  aclk,
    input  word_t lane0,
    input  word_t lane1,
    output word_t sum
);

    word_t sum_reg;

    always_ff @(posedge aclk) begin
        sum_reg <= sadd(lane0, lane1);
    end

    assign sum = sum_reg;

endmodule

// ----- rtl/core/kfv_div.sv -----
// restoring divider for (num * 2^FB) / den, one quotient bit per cycle, rounded and saturated
`timescale 1ns / 1ps

module kfv_div import kfv_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DW-1:0]    den_reg;
    logic [QW-1:0]    divd_reg;
    logic [DW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;
    word_t            res_reg;

    logic [DW-1:0]    num_mag;
    logic [DW-1:0]    den_mag;
    logic [DW:0]      rem_sh;
    logic             ge;
    logic [DW:0]      rem_sub;
    logic             rnd;
    logic [QW-1:0]    quo_rnd;

    assign num_mag = req.num[DW-1] ? DW'(-req.num) : DW'(req.num);
    assign den_mag = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
    assign rem_sh  = {rem_reg, divd_reg[QW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign rnd     = rem_reg >= (den_reg - rem_reg);
    assign quo_rnd = quo_reg + QW'(rnd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS);
                neg_reg  <= req.num[DW-1] ^ req.den[DW-1];
                den_reg  <= den_mag;
                divd_reg <= {num_mag, {FB{1'b0}}};
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg  <= cnt_reg - 1'b1;
                    divd_reg <= {divd_reg[QW-2:0], 1'b0};
                    rem_reg  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                    quo_reg  <= {quo_reg[QW-2:0], ge};
                end else begin
                    res_reg  <= sat_mag(neg_reg, PW'(quo_rnd));
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = res_reg;

endmodule

// ----- rtl/core/kalman_filter_2state_velocity_core.sv -----
// two-state constant-velocity kalman filter: two multiplier lanes, merge stage, shared divider
// predict item: result shown after three lane passes
// update item: four passes of the bit-serial divider plus eleven lane passes, the first
// computing the determinant; a singular update skips the divider and shows its result
// one item in work at a time; the next is taken while the previous result waits in m_
// aresetn (sync, low) restores config defaults, zero estimates and identity covariance
`timescale 1ns / 1ps

module kalman_filter_2state_velocity_core import kfv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [2*DW-1:0]  s_tdata,   // meas_pos, meas_vel
    input  logic             s_tuser,   // func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [2*DW-1:0]  m_tdata,   // est_pos, est_vel
    output logic             m_tuser,   // singular
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        OP_P1, OP_P2, OP_P3, OP_DET,
        OP_K00, OP_K01, OP_K10, OP_K11,
        OP_XP, OP_XV, OP_N0, OP_N1, OP_N2, OP_N3
    } op_t;

    state_t          state_reg;
    op_t             op_reg;
    logic [1:0]      phase_reg;
    logic [1:0]      div_idx_reg;
    logic            div_start_reg;
    logic            sing_reg;

    logic [DT_W-1:0]  step_time_reg;
    logic [CFG_W-1:0] q_pos_reg;
    logic [CFG_W-1:0] q_vel_reg;
    logic [CFG_W-1:0] r_pos_reg;
    logic [CFG_W-1:0] r_vel_reg;

    word_t pos_reg;
    word_t vel_reg;
    word_t cov_reg [4];

    word_t y0_reg;
    word_t y1_reg;
    word_t det_reg;
    word_t ap00_reg;
    word_t ap01_reg;
    word_t inv_reg [4];
    word_t k_reg   [4];
    word_t n_reg   [4];

    logic            m_tvalid_reg;
    logic [2*DW-1:0] m_tdata_reg;
    logic            m_tuser_reg;

    word_t dt, qp, qv, rp, rv;
    word_t s00, s01, s10, s11;
    word_t m00, m01, m10, m11;
    word_t a0, b0, a1, b1;
    word_t prod0, prod1, sum;
    word_t det_new;
    word_t meas_pos, meas_vel;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     s_fire;
    logic     out_free;

    assign dt  = word_t'({{(DW-DT_W){1'b0}}, step_time_reg});
    assign qp  = word_t'({1'b0, q_pos_reg});
    assign qv  = word_t'({1'b0, q_vel_reg});
    assign rp  = word_t'({1'b0, r_pos_reg});
    assign rv  = word_t'({1'b0, r_vel_reg});

    assign s00 = sadd(cov_reg[0], rp);
    assign s01 = cov_reg[1];
    assign s10 = cov_reg[2];
    assign s11 = sadd(cov_reg[3], rv);

    assign m00 = ssub(ONE, k_reg[0]);
    assign m01 = sneg(k_reg[1]);
    assign m10 = sneg(k_reg[2]);
    assign m11 = ssub(ONE, k_reg[3]);

    assign meas_pos = word_t'(s_tdata[DW-1:0]);
    assign meas_vel = word_t'(s_tdata[2*DW-1:DW]);

    assign det_new  = ssub(prod0, prod1);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
        unique case (op_reg)
            OP_P1:  begin a0 = dt;       b0 = cov_reg[2]; a1 = dt;       b1 = cov_reg[3]; end
            OP_P2:  begin a0 = dt;       b0 = ap01_reg;   a1 = dt;       b1 = cov_reg[3]; end
            OP_P3:  begin a0 = dt;       b0 = vel_reg;    end
            OP_DET: begin a0 = s00;      b0 = s11;        a1 = s01;      b1 = s10;        end
            OP_K00: begin a0 = cov_reg[0]; b0 = inv_reg[0]; a1 = cov_reg[1]; b1 = inv_reg[2]; end
            OP_K01: begin a0 = cov_reg[0]; b0 = inv_reg[1]; a1 = cov_reg[1]; b1 = inv_reg[3]; end
            OP_K10: begin a0 = cov_reg[2]; b0 = inv_reg[0]; a1 = cov_reg[3]; b1 = inv_reg[2]; end
            OP_K11: begin a0 = cov_reg[2]; b0 = inv_reg[1]; a1 = cov_reg[3]; b1 = inv_reg[3]; end
            OP_XP:  begin a0 = k_reg[0]; b0 = y0_reg;     a1 = k_reg[1]; b1 = y1_reg;     end
            OP_XV:  begin a0 = k_reg[2]; b0 = y0_reg;     a1 = k_reg[3]; b1 = y1_reg;     end
            OP_N0:  begin a0 = m00;      b0 = cov_reg[0]; a1 = m01;      b1 = cov_reg[2]; end
            OP_N1:  begin a0 = m00;      b0 = cov_reg[1]; a1 = m01;      b1 = cov_reg[3]; end
            OP_N2:  begin a0 = m10;      b0 = cov_reg[0]; a1 = m11;      b1 = cov_reg[2]; end
            OP_N3:  begin a0 = m10;      b0 = cov_reg[1]; a1 = m11;      b1 = cov_reg[3]; end
            default: begin end
        endcase
    end

    always_comb begin
        div_req.start = div_start_reg;
        div_req.den   = det_reg;
        unique case (div_idx_reg)
            2'd0:    div_req.num = s11;
            2'd1:    div_req.num = sneg(s01);
            2'd2:    div_req.num = sneg(s10);
            default: div_req.num = s00;
        endcase
    end

    kfv_lane u_lane0 (.aclk(aclk), .op_a(a0), .op_b(b0), .prod(prod0));
    kfv_lane u_lane1 (.aclk(aclk), .op_a(a1), .op_b(b1), .prod(prod1));

    kfv_merge u_merge (.aclk(aclk), .lane0(prod0), .lane1(prod1), .sum(sum));

    kfv_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= DT_W'(655);
            q_pos_reg     <= CFG_W'(6554);
            q_vel_reg     <= CFG_W'(6554);
            r_pos_reg     <= CFG_W'(72090);
            r_vel_reg     <= CFG_W'(655);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_TIME: step_time_reg <= cfg_wdata[DT_W-1:0];
                CFG_Q_POS:     q_pos_reg     <= cfg_wdata;
                CFG_Q_VEL:     q_vel_reg     <= cfg_wdata;
                CFG_R_POS:     r_pos_reg     <= cfg_wdata;
                CFG_R_VEL:     r_vel_reg     <= cfg_wdata;
                default: begin end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_P1;
            phase_reg     <= '0;
            div_idx_reg   <= '0;
            div_start_reg <= 1'b0;
            sing_reg      <= 1'b0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            cov_reg[0]    <= ONE;
            cov_reg[1]    <= '0;
            cov_reg[2]    <= '0;
            cov_reg[3]    <= ONE;
            m_tvalid_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_MUL;
                        phase_reg <= '0;
                        sing_reg  <= 1'b0;
                        if (s_tuser) begin
                            op_reg <= OP_DET;
                            y0_reg <= ssub(meas_pos, pos_reg);
                            y1_reg <= ssub(meas_vel, vel_reg);
                        end else begin
                            op_reg <= OP_P1;
                        end
                    end
                end
                ST_MUL: begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == 2'd3) begin
                        unique case (op_reg)
                            OP_P1: begin
                                ap00_reg <= sadd(cov_reg[0], prod0);
                                ap01_reg <= sadd(cov_reg[1], prod1);
                                op_reg   <= OP_P2;
                            end
                            OP_P2: begin
                                n_reg[0] <= sadd(sadd(ap00_reg, prod0), qp);
                                n_reg[2] <= sadd(cov_reg[2], prod1);
                                op_reg   <= OP_P3;
                            end
                            OP_P3: begin
                                pos_reg    <= sadd(pos_reg, prod0);
                                cov_reg[0] <= n_reg[0];
                                cov_reg[1] <= ap01_reg;
                                cov_reg[2] <= n_reg[2];
                                cov_reg[3] <= sadd(cov_reg[3], qv);
                                state_reg  <= ST_OUT;
                            end
                            OP_DET: begin
                                det_reg <= det_new;
                                if (det_new == '0) begin
                                    sing_reg  <= 1'b1;
                                    state_reg <= ST_OUT;
                                end else begin
                                    div_idx_reg   <= '0;
                                    div_start_reg <= 1'b1;
                                    state_reg     <= ST_DIV;
                                end
                            end
                            OP_K00: begin k_reg[0] <= sum; op_reg <= OP_K01; end
                            OP_K01: begin k_reg[1] <= sum; op_reg <= OP_K10; end
                            OP_K10: begin k_reg[2] <= sum; op_reg <= OP_K11; end
                            OP_K11: begin k_reg[3] <= sum; op_reg <= OP_XP;  end
                            OP_XP:  begin pos_reg <= sadd(pos_reg, sum); op_reg <= OP_XV; end
                            OP_XV:  begin vel_reg <= sadd(vel_reg, sum); op_reg <= OP_N0; end
                            OP_N0:  begin n_reg[0] <= sum; op_reg <= OP_N1; end
                            OP_N1:  begin n_reg[1] <= sum; op_reg <= OP_N2; end
                            OP_N2:  begin n_reg[2] <= sum; op_reg <= OP_N3; end
                            OP_N3: begin
                                cov_reg[0] <= n_reg[0];
                                cov_reg[1] <= n_reg[1];
                                cov_reg[2] <= n_reg[2];
                                cov_reg[3] <= sum;
                                state_reg  <= ST_OUT;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        inv_reg[div_idx_reg] <= div_rsp.quo;
                        if (div_idx_reg == 2'd3) begin
                            op_reg    <= OP_K00;
                            phase_reg <= '0;
                            state_reg <= ST_MUL;
                        end else begin
                            div_idx_reg   <= div_idx_reg + 1'b1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {vel_reg, pos_reg};
                        m_tuser_reg  <= sing_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/core/kfv_checker.sv -----
// port-level checker for the kalman filter core, attached by bind
`timescale 1ns / 1ps

module kfv_checker import kfv_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [2*DW-1:0] m_tdata,
    input logic            m_tuser
);

    logic [1:0] pend_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // items taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 2'(s_fire) - 2'(m_fire);
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without a pending item");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many items in flight");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("item taken while previous one in work");

endmodule

bind kalman_filter_2state_velocity_core kfv_checker u_kfv_checker (.*);
